FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, operation and status codes, and the command and status
// bundles that join the sorted priority queue controller and datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 8;
  localparam int COST_BITS  = 16;

  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ENT_W      = 2 * COORD_BITS + COST_BITS;
  localparam int IN_DATA_W  = ((ENT_W + 7) / 8) * 8;
  localparam int RES_W      = ENT_W + CNT_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_POP    = 2'd1,
    FN_FIND   = 2'd2,
    FN_REMOVE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_LAST,
    IDX_INC,
    IDX_DEC
  } idx_sel_t;

  typedef enum logic [1:0] {
    WA_IDX,
    WA_UP,
    WA_DOWN
  } wr_addr_sel_t;

  typedef enum logic {
    WD_ENTRY,
    WD_NEW
  } wr_data_sel_t;

  typedef struct packed {
    logic         req_load;
    logic         res_clr;
    logic         res_cap;
    logic         res_set;
    status_t      res_status;
    idx_sel_t     idx_sel;
    logic         wr_en;
    wr_addr_sel_t wr_addr_sel;
    wr_data_sel_t wr_data_sel;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         out_load;
  } spq_cmd_t;

  typedef struct packed {
    func_t func;
    logic  empty;
    logic  full;
    logic  idx_zero;
    logic  more;
    logic  cost_gt;
    logic  match;
  } spq_sts_t;

endpackage

FILE: design/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Request and result registers, the entry store, the walk index, the entry
// count and the comparators used by the controller.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [spq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  input  spq_pkg::spq_cmd_t              cmd,
  output spq_pkg::spq_sts_t              sts,
  output logic [spq_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     out_tuser
);

  import spq_pkg::*;

  func_t                 req_func_r, req_func_nxt;
  logic [COORD_BITS-1:0] req_x_r, req_x_nxt;
  logic [COORD_BITS-1:0] req_y_r, req_y_nxt;
  logic [COST_BITS-1:0]  req_cost_r, req_cost_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [ENT_W-1:0]      res_ent_r, res_ent_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [RES_W-1:0]      out_res_r, out_res_nxt;

  logic [ENT_W-1:0]      rd_data;
  logic [ENT_W-1:0]      wr_data;
  logic [IDX_W-1:0]      wr_addr;
  logic [CNT_W-1:0]      idx_p1;
  logic [COORD_BITS-1:0] ent_x;
  logic [COORD_BITS-1:0] ent_y;
  logic [COST_BITS-1:0]  ent_cost;

  assign ent_x    = rd_data[COORD_BITS-1:0];
  assign ent_y    = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign ent_cost = rd_data[ENT_W-1:2*COORD_BITS];
  assign idx_p1   = CNT_W'(idx_r) + CNT_W'(1);

  always_comb begin
    req_func_nxt = req_func_r;
    req_x_nxt    = req_x_r;
    req_y_nxt    = req_y_r;
    req_cost_nxt = req_cost_r;
    if (cmd.req_load) begin
      req_func_nxt = func_t'(in_tuser);
      req_x_nxt    = in_tdata[COORD_BITS-1:0];
      req_y_nxt    = in_tdata[2*COORD_BITS-1:COORD_BITS];
      req_cost_nxt = in_tdata[ENT_W-1:2*COORD_BITS];
    end
  end

  always_comb begin
    unique case (cmd.idx_sel)
      IDX_HOLD: idx_nxt = idx_r;
      IDX_ZERO: idx_nxt = '0;
      IDX_LAST: idx_nxt = IDX_W'(count_r - CNT_W'(1));
      IDX_INC:  idx_nxt = idx_r + IDX_W'(1);
      IDX_DEC:  idx_nxt = idx_r - IDX_W'(1);
      default:  idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    unique case (cmd.wr_addr_sel)
      WA_IDX:  wr_addr = idx_r;
      WA_UP:   wr_addr = idx_r + IDX_W'(1);
      WA_DOWN: wr_addr = idx_r - IDX_W'(1);
      default: wr_addr = idx_r;
    endcase
  end

  assign wr_data = (cmd.wr_data_sel == WD_NEW) ? {req_cost_r, req_y_r, req_x_r} : rd_data;

  spq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  always_comb begin
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    if (cmd.res_clr) begin
      res_status_nxt = ST_DONE;
      res_ent_nxt    = '0;
    end
    if (cmd.res_cap) begin
      res_ent_nxt = rd_data;
    end
    if (cmd.res_set) begin
      res_status_nxt = cmd.res_status;
    end
  end

  always_comb begin
    out_status_nxt = out_status_r;
    out_res_nxt    = out_res_r;
    if (cmd.out_load) begin
      out_status_nxt = res_status_r;
      out_res_nxt    = {count_r, res_ent_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_func_r   <= req_func_nxt;
    req_x_r      <= req_x_nxt;
    req_y_r      <= req_y_nxt;
    req_cost_r   <= req_cost_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    out_status_r <= out_status_nxt;
    out_res_r    <= out_res_nxt;
  end

  assign sts.func     = req_func_r;
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CNT_W'(CAPACITY));
  assign sts.idx_zero = (idx_r == '0);
  assign sts.more     = (idx_p1 < count_r);
  assign sts.cost_gt  = (ent_cost > req_cost_r);
  assign sts.match    = (ent_x == req_x_r) && (ent_y == req_y_r);

  assign out_tdata = OUT_DATA_W'(out_res_r);
  assign out_tuser = out_status_r;

endmodule

FILE: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for the sorted priority queue. It walks the entry store one
// entry per read and evaluate pair to place, look up or close up entries.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  spq_pkg::spq_sts_t sts,
  output spq_pkg::spq_cmd_t cmd
);

  import spq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_EV  = 4'd3;
  localparam logic [3:0] S_INS_NEW = 4'd4;
  localparam logic [3:0] S_SCN_RD  = 4'd5;
  localparam logic [3:0] S_SCN_EV  = 4'd6;
  localparam logic [3:0] S_SH_RD   = 4'd7;
  localparam logic [3:0] S_SH_EV   = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       hit;

  assign hit = (sts.func == FN_POP) || sts.match;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          cmd.res_clr  = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.func)
          FN_INSERT: begin
            if (sts.full) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_FULL;
              state_nxt      = S_FIN;
            end else if (sts.empty) begin
              cmd.idx_sel = IDX_ZERO;
              state_nxt   = S_INS_NEW;
            end else begin
              cmd.idx_sel = IDX_LAST;
              state_nxt   = S_INS_RD;
            end
          end
          FN_POP: begin
            if (sts.empty) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_nxt      = S_FIN;
            end else begin
              cmd.idx_sel = IDX_ZERO;
              state_nxt   = S_SCN_RD;
            end
          end
          FN_FIND, FN_REMOVE: begin
            if (sts.empty) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              state_nxt      = S_FIN;
            end else begin
              cmd.idx_sel = IDX_ZERO;
              state_nxt   = S_SCN_RD;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_INS_RD: state_nxt = S_INS_EV;
      S_INS_EV: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_UP;
        if (sts.cost_gt) begin
          cmd.wr_data_sel = WD_ENTRY;
          if (sts.idx_zero) begin
            state_nxt = S_INS_NEW;
          end else begin
            cmd.idx_sel = IDX_DEC;
            state_nxt   = S_INS_RD;
          end
        end else begin
          cmd.wr_data_sel = WD_NEW;
          cmd.cnt_inc     = 1'b1;
          state_nxt       = S_FIN;
        end
      end
      S_INS_NEW: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_IDX;
        cmd.wr_data_sel = WD_NEW;
        cmd.cnt_inc     = 1'b1;
        state_nxt       = S_FIN;
      end
      S_SCN_RD: state_nxt = S_SCN_EV;
      S_SCN_EV: begin
        if (hit) begin
          cmd.res_cap = 1'b1;
          if (sts.func == FN_FIND) begin
            state_nxt = S_FIN;
          end else if (sts.more) begin
            cmd.idx_sel = IDX_INC;
            state_nxt   = S_SH_RD;
          end else begin
            cmd.cnt_dec = 1'b1;
            state_nxt   = S_FIN;
          end
        end else if (sts.more) begin
          cmd.idx_sel = IDX_INC;
          state_nxt   = S_SCN_RD;
        end else begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end
      end
      S_SH_RD: state_nxt = S_SH_EV;
      S_SH_EV: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_DOWN;
        cmd.wr_data_sel = WD_ENTRY;
        if (sts.more) begin
          cmd.idx_sel = IDX_INC;
          state_nxt   = S_SH_RD;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

FILE: design/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Open-list priority queue for grid path search, kept sorted by cost.
//
// The input channel carries one operation per transaction: the opcode in
// in_tuser (insert, pop, find, remove) and the coordinates and cost in
// in_tdata. Each operation gives exactly one result transaction with a
// status code in out_tuser and the entry fields and occupancy in out_tdata.
// Operations are handled one at a time. Each store entry read takes a read
// state and an evaluate state, set by the single read port of the
// entry store: an insert reads the entries of higher cost and the one it
// lands behind, plus a separate write state when it lands at the head; a find
// reads up to its match; a pop, a remove or a miss reads every entry held.
// The result is loaded into the output register as the sequencer leaves its
// finish state for idle, where it takes the next operation. A finished
// result sits in an output register while the next operation runs; if it is
// still stalled when the following result is ready, the sequencer waits for
// it. Reset empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]  in_tdata,   // x, y, cost
  input  logic [1:0]                     in_tuser,   // func
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0] out_tdata,  // out_x, out_y, out_cost, occupancy
  output logic [1:0]                     out_tuser   // status
);

  import spq_pkg::*;

  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  spq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_priority_queue_top. A scoreboard keeps its
// own sorted copy of the open list, predicts one result for every accepted
// operation and compares each returned transaction field by field. Stimulus
// is a short directed run, then random phases that fill the queue to its
// capacity and drain it again under four patterns of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 2 * CAPACITY + 20;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 250;

  typedef enum int {
    SHAPE_FILL,
    SHAPE_DRAIN,
    SHAPE_MIXED
  } shape_t;

  typedef struct packed {
    status_t                status;
    logic [COORD_BITS-1:0]  px;
    logic [COORD_BITS-1:0]  py;
    logic [COST_BITS-1:0]   pcost;
    logic [CNT_W-1:0]       occ;
  } queue_result_t;

  class queue_scoreboard;
    logic [COORD_BITS-1:0] ent_x [CAPACITY];
    logic [COORD_BITS-1:0] ent_y [CAPACITY];
    logic [COST_BITS-1:0]  ent_c [CAPACITY];
    int                    count;
    queue_result_t         expected_q [$];
    int                    errors;
    int                    checked;
    int                    n_full;
    int                    n_empty;
    int                    n_miss;

    function new();
      count   = 0;
      errors  = 0;
      checked = 0;
      n_full  = 0;
      n_empty = 0;
      n_miss  = 0;
    endfunction

    function int locate(logic [COORD_BITS-1:0] qx, logic [COORD_BITS-1:0] qy);
      for (int i = 0; i < count; i++) begin
        if (ent_x[i] == qx && ent_y[i] == qy) return i;
      end
      return -1;
    endfunction

    function void remove_at(int pos);
      for (int i = pos; i + 1 < count; i++) begin
        ent_x[i] = ent_x[i+1];
        ent_y[i] = ent_y[i+1];
        ent_c[i] = ent_c[i+1];
      end
      count--;
    endfunction

    function void note_input(func_t fn, logic [COORD_BITS-1:0] qx,
                             logic [COORD_BITS-1:0] qy, logic [COST_BITS-1:0] qc);
      queue_result_t r;
      int            pos;
      r = '0;
      r.status = ST_DONE;
      case (fn)
        FN_INSERT: begin
          if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            pos = 0;
            while (pos < count && ent_c[pos] <= qc) pos++;
            for (int i = count; i > pos; i--) begin
              ent_x[i] = ent_x[i-1];
              ent_y[i] = ent_y[i-1];
              ent_c[i] = ent_c[i-1];
            end
            ent_x[pos] = qx;
            ent_y[pos] = qy;
            ent_c[pos] = qc;
            count++;
          end
        end
        FN_POP: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.px    = ent_x[0];
            r.py    = ent_y[0];
            r.pcost = ent_c[0];
            remove_at(0);
          end
        end
        default: begin
          pos = locate(qx, qy);
          if (pos < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.px    = ent_x[pos];
            r.py    = ent_y[pos];
            r.pcost = ent_c[pos];
            if (fn == FN_REMOVE) remove_at(pos);
          end
        end
      endcase
      r.occ = CNT_W'(count);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int e, int a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic [1:0] u);
      queue_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual %h/%0d",
                 $time, d, u);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (e.status == ST_FULL) n_full++;
      if (e.status == ST_EMPTY) n_empty++;
      if (e.status == ST_NOTFOUND) n_miss++;
      compare_field("status", int'(e.status), int'(u));
      compare_field("out_x", int'(e.px), int'(d[COORD_BITS-1:0]));
      compare_field("out_y", int'(e.py), int'(d[2*COORD_BITS-1:COORD_BITS]));
      compare_field("out_cost", int'(e.pcost), int'(d[ENT_W-1:2*COORD_BITS]));
      compare_field("occupancy", int'(e.occ), int'(d[RES_W-1:ENT_W]));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  queue_scoreboard sb;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              quiet_cycles = 0;

  sorted_priority_queue_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(func_t'(in_tuser), in_tdata[COORD_BITS-1:0],
                      in_tdata[2*COORD_BITS-1:COORD_BITS], in_tdata[ENT_W-1:2*COORD_BITS]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, sb.expected_q.size());
      $display("sorted_priority_queue_top verification failed");
      $finish;
    end
  end

  task automatic send_op(func_t fn, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                         logic [COST_BITS-1:0] c);
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= IN_DATA_W'({c, y, x});
    do @(posedge clk); while (!in_tready);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic random_op(shape_t shape);
    func_t                 fn;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COST_BITS-1:0]  c;
    int                    r;
    int                    idx;
    int                    lim_ins;
    int                    lim_pop;
    int                    lim_find;
    case (shape)
      SHAPE_FILL:  begin lim_ins = 75; lim_pop = 85; lim_find = 93; end
      SHAPE_DRAIN: begin lim_ins = 15; lim_pop = 65; lim_find = 75; end
      default:     begin lim_ins = 40; lim_pop = 65; lim_find = 85; end
    endcase
    r = int'($urandom_range(99));
    if (r < lim_ins) fn = FN_INSERT;
    else if (r < lim_pop) fn = FN_POP;
    else if (r < lim_find) fn = FN_FIND;
    else fn = FN_REMOVE;
    if ((fn == FN_FIND || fn == FN_REMOVE) && sb.count > 0 && $urandom_range(99) < 65) begin
      idx = int'($urandom_range(sb.count - 1));
      x   = sb.ent_x[idx];
      y   = sb.ent_y[idx];
    end else if ($urandom_range(99) < 70) begin
      x = COORD_BITS'($urandom_range(3));
      y = COORD_BITS'($urandom_range(3));
    end else begin
      x = COORD_BITS'($urandom_range(255));
      y = COORD_BITS'($urandom_range(255));
    end
    if ($urandom_range(99) < 50) c = COST_BITS'($urandom_range(15));
    else c = COST_BITS'($urandom_range(65535));
    send_op(fn, x, y, c);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(FN_POP,    8'd0,   8'd0,   16'd0);
    send_op(FN_FIND,   8'd5,   8'd5,   16'd0);
    send_op(FN_REMOVE, 8'd5,   8'd5,   16'd0);
    send_op(FN_INSERT, 8'd0,   8'd0,   16'd0);
    send_op(FN_INSERT, 8'd255, 8'd255, 16'd65535);
    send_op(FN_INSERT, 8'd1,   8'd2,   16'd100);
    send_op(FN_INSERT, 8'd3,   8'd4,   16'd100);
    send_op(FN_INSERT, 8'd1,   8'd2,   16'd100);
    send_op(FN_FIND,   8'd1,   8'd2,   16'd0);
    send_op(FN_FIND,   8'd9,   8'd9,   16'd0);
    send_op(FN_REMOVE, 8'd3,   8'd4,   16'd0);
    send_op(FN_REMOVE, 8'd7,   8'd7,   16'd0);
    send_op(FN_INSERT, 8'hAA,  8'h55,  16'h5555);
    send_op(FN_INSERT, 8'h55,  8'hAA,  16'hAAAA);
    send_op(FN_POP,    8'hFF,  8'hFF,  16'hFFFF);
    send_op(FN_POP,    8'd0,   8'd0,   16'd0);
    send_op(FN_FIND,   8'd255, 8'd255, 16'd0);
    send_op(FN_REMOVE, 8'd255, 8'd255, 16'd0);
    send_op(FN_POP,    8'd0,   8'd0,   16'd0);
    send_op(FN_POP,    8'd0,   8'd0,   16'd0);
    send_op(FN_POP,    8'd0,   8'd0,   16'd0);
    send_op(FN_POP,    8'd0,   8'd0,   16'd0);

    for (int p = 0; p < PHASES; p++) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (sb.expected_q.size() != 0);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i < 120) random_op(SHAPE_FILL);
        else if (i < 220) random_op(SHAPE_DRAIN);
        else random_op(SHAPE_MIXED);
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d operations, %0d inserts dropped on a full queue, %0d empty pops,",
             sb.checked, sb.n_full, sb.n_empty);
    $display("%0d coordinate misses, across %0d idling phases.", sb.n_miss, PHASES);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("sorted_priority_queue_top verification clean");
    end else begin
      $display("sorted_priority_queue_top verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/spq_pkg.sv
design/spq_ram.sv
design/spq_datapath.sv
design/spq_ctrl.sv
design/sorted_priority_queue_top.sv
tb/tb.sv
